/* rtl/core/kwl_pkg.sv */
package kwl_pkg;

  localparam int CH_W     = 8;
  localparam int FIELD_W  = 14;
  localparam int KIND_W   = 5;
  localparam int PREFIX_W = 56;
  localparam int RUN_W    = FIELD_W;

  localparam logic [FIELD_W-1:0] FIELD_MAX = {FIELD_W{1'b1}};

  // Longest word that can still be a keyword
  localparam int KW_MAX_LEN = PREFIX_W / CH_W;

  localparam int TEXT_DEPTH_DEF = 16384;

  // Output queue sizing
  localparam int OQ_DEPTH = 4;
  localparam int OQ_PTR_W = $clog2(OQ_DEPTH);
  localparam int OQ_CNT_W = OQ_PTR_W + 1;

  // Source characters with a meaning of their own
  localparam logic [CH_W-1:0] CH_NUL    = 8'h00;
  localparam logic [CH_W-1:0] CH_LPAREN = "(";
  localparam logic [CH_W-1:0] CH_RPAREN = ")";
  localparam logic [CH_W-1:0] CH_LBRACE = "{";
  localparam logic [CH_W-1:0] CH_RBRACE = "}";
  localparam logic [CH_W-1:0] CH_EQUAL  = "=";
  localparam logic [CH_W-1:0] CH_COMMA  = ",";
  localparam logic [CH_W-1:0] CH_PLUS   = "+";
  localparam logic [CH_W-1:0] CH_STAR   = "*";
  localparam logic [CH_W-1:0] CH_SLASH  = "/";
  localparam logic [CH_W-1:0] CH_AT     = "@";
  localparam logic [CH_W-1:0] CH_DASH   = "-";
  localparam logic [CH_W-1:0] CH_GT     = ">";
  localparam logic [CH_W-1:0] CH_ZERO   = "0";
  localparam logic [CH_W-1:0] CH_X      = "x";

  typedef enum logic [KIND_W-1:0] {
    TK_INT      = 5'd0,
    TK_ADDR     = 5'd1,
    TK_ADDRARR  = 5'd2,
    TK_ARR      = 5'd3,
    TK_MEM      = 5'd4,
    TK_STR      = 5'd5,
    TK_MAIN     = 5'd6,
    TK_ARROW    = 5'd7,
    TK_EQUAL    = 5'd8,
    TK_LPAREN   = 5'd9,
    TK_RPAREN   = 5'd10,
    TK_LBRACE   = 5'd11,
    TK_RBRACE   = 5'd12,
    TK_AT       = 5'd13,
    TK_STATIC   = 5'd14,
    TK_SUM      = 5'd15,
    TK_SUB      = 5'd16,
    TK_DIV      = 5'd17,
    TK_MULT     = 5'd18,
    TK_INTDATA  = 5'd19,
    TK_ADDRDATA = 5'd20,
    TK_IDENT    = 5'd21,
    TK_STRDATA  = 5'd22,
    TK_NULL     = 5'd23,
    TK_COMMA    = 5'd24,
    TK_FOR      = 5'd25,
    TK_IF       = 5'd26,
    TK_PRINT    = 5'd27,
    TK_END      = 5'd28
  } token_kind_t;

  typedef struct packed {
    token_kind_t         kind;
    logic [FIELD_W-1:0]  start;
    logic [FIELD_W-1:0]  len;
    logic                last;
  } kwl_result_t;

  // Results of one byte, packed from slot 0; n counts valid slots
  typedef struct packed {
    logic [1:0]  n;
    kwl_result_t r0;
    kwl_result_t r1;
  } kwl_push_t;

  localparam int KW_COUNT = 14;

  // Keywords right-justified, zero-padded on the left
  localparam logic [PREFIX_W-1:0] KW_TEXT [KW_COUNT] = '{
    56'("int"),  56'("addr"), 56'("addrArr"), 56'("arr"),    56'("mem"),
    56'("str"),  56'("main"), 56'("static"),  56'("NULL"),   56'("null"),
    56'("Null"), 56'("for"),  56'("if"),      56'("print")
  };

  localparam token_kind_t KW_KIND [KW_COUNT] = '{
    TK_INT,  TK_ADDR, TK_ADDRARR, TK_ARR,  TK_MEM,
    TK_STR,  TK_MAIN, TK_STATIC,  TK_NULL, TK_NULL,
    TK_NULL, TK_FOR,  TK_IF,      TK_PRINT
  };

  function automatic token_kind_t kw_lookup(logic [PREFIX_W-1:0] prefix);
    token_kind_t k;
    k = TK_IDENT;
    for (int i = 0; i < KW_COUNT; i++) begin
      if (prefix == KW_TEXT[i]) begin
        k = KW_KIND[i];
      end
    end
    return k;
  endfunction

endpackage

/* rtl/core/kwl_scan.sv */
module kwl_scan #(
  parameter int TEXT_DEPTH = kwl_pkg::TEXT_DEPTH_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    fire,
  input  logic [kwl_pkg::CH_W-1:0] ch,
  output kwl_pkg::kwl_push_t      push
);
  import kwl_pkg::*;

  localparam int POS_W = $clog2(TEXT_DEPTH);
  localparam int CAP_W = (POS_W > FIELD_W) ? POS_W : FIELD_W;
  localparam logic [POS_W-1:0] POS_MAX = POS_W'(TEXT_DEPTH - 1);

  typedef enum logic [5:0] {
    M_IDLE = 6'b000001,
    M_DASH = 6'b000010,
    M_WORD = 6'b000100,
    M_ZERO = 6'b001000,
    M_DEC  = 6'b010000,
    M_HEX  = 6'b100000
  } mode_t;

  mode_t                mode, mode_next;
  logic [POS_W-1:0]     pos, pos_next;
  logic [POS_W-1:0]     tstart, tstart_next;
  logic [RUN_W-1:0]     run, run_next;
  logic [PREFIX_W-1:0]  prefix, prefix_next;

  logic                 is_alpha, is_digit, is_alnum;
  logic                 done, ended;
  logic                 held_emit, new_emit;
  kwl_result_t          held_res, new_res;
  logic [RUN_W-1:0]     run_inc;
  token_kind_t          word_kind;

  function automatic logic [FIELD_W-1:0] cap_pos(logic [POS_W-1:0] v);
    logic [CAP_W-1:0] w;
    w = CAP_W'(v);
    if (w >= CAP_W'(FIELD_MAX)) begin
      return FIELD_MAX;
    end
    return w[FIELD_W-1:0];
  endfunction

  assign is_alpha = (ch inside {["a":"z"], ["A":"Z"], "_"});
  assign is_digit = (ch inside {["0":"9"]});
  assign is_alnum = is_alpha | is_digit;
  assign run_inc  = (run != FIELD_MAX) ? run + 1'b1 : run;
  assign word_kind = (run > RUN_W'(KW_MAX_LEN)) ? TK_IDENT : kw_lookup(prefix);

  always_comb begin
    mode_next   = mode;
    tstart_next = tstart;
    run_next    = run;
    prefix_next = prefix;
    done        = 1'b0;
    ended       = 1'b0;
    held_emit   = 1'b0;
    new_emit    = 1'b0;
    held_res    = '{kind: TK_IDENT, start: cap_pos(tstart), len: run, last: 1'b0};
    new_res     = '{kind: TK_END, start: cap_pos(pos), len: '0, last: 1'b1};

    // Close or extend the open token
    case (mode)
      M_DASH: begin
        held_emit = 1'b1;
        if (ch == CH_GT) begin
          held_res.kind = TK_ARROW;
          held_res.len  = FIELD_W'(2);
          mode_next     = M_IDLE;
          done          = 1'b1;
        end else begin
          held_res.kind = TK_SUB;
          held_res.len  = FIELD_W'(1);
        end
      end
      M_WORD: begin
        if (is_alnum) begin
          if (run < RUN_W'(KW_MAX_LEN)) begin
            prefix_next = {prefix[PREFIX_W-CH_W-1:0], ch};
          end
          run_next = run_inc;
          done     = 1'b1;
        end else begin
          held_emit     = 1'b1;
          held_res.kind = word_kind;
        end
      end
      M_ZERO: begin
        if (ch == CH_X) begin
          mode_next = M_HEX;
          run_next  = RUN_W'(2);
          done      = 1'b1;
        end else if (is_digit) begin
          mode_next = M_DEC;
          run_next  = run_inc;
          done      = 1'b1;
        end else begin
          held_emit     = 1'b1;
          held_res.kind = TK_INTDATA;
        end
      end
      M_DEC: begin
        if (is_digit) begin
          run_next = run_inc;
          done     = 1'b1;
        end else begin
          held_emit     = 1'b1;
          held_res.kind = TK_INTDATA;
        end
      end
      M_HEX: begin
        if (is_alnum) begin
          run_next = run_inc;
          done     = 1'b1;
        end else begin
          held_emit     = 1'b1;
          held_res.kind = TK_ADDRDATA;
        end
      end
      default: begin
      end
    endcase

    // Start something new from this byte
    if (!done) begin
      mode_next   = M_IDLE;
      new_res.len = FIELD_W'(1);
      case (ch)
        CH_NUL: begin
          new_emit    = 1'b1;
          new_res.len = '0;
          ended       = 1'b1;
        end
        CH_LPAREN: begin new_emit = 1'b1; new_res.kind = TK_LPAREN; end
        CH_RPAREN: begin new_emit = 1'b1; new_res.kind = TK_RPAREN; end
        CH_LBRACE: begin new_emit = 1'b1; new_res.kind = TK_LBRACE; end
        CH_RBRACE: begin new_emit = 1'b1; new_res.kind = TK_RBRACE; end
        CH_EQUAL:  begin new_emit = 1'b1; new_res.kind = TK_EQUAL;  end
        CH_COMMA:  begin new_emit = 1'b1; new_res.kind = TK_COMMA;  end
        CH_PLUS:   begin new_emit = 1'b1; new_res.kind = TK_SUM;    end
        CH_STAR:   begin new_emit = 1'b1; new_res.kind = TK_MULT;   end
        CH_SLASH:  begin new_emit = 1'b1; new_res.kind = TK_DIV;    end
        CH_AT:     begin new_emit = 1'b1; new_res.kind = TK_AT;     end
        CH_DASH: begin
          mode_next   = M_DASH;
          tstart_next = pos;
          run_next    = RUN_W'(1);
        end
        default: begin
          if (is_alpha) begin
            mode_next   = M_WORD;
            tstart_next = pos;
            run_next    = RUN_W'(1);
            prefix_next = PREFIX_W'(ch);
          end else if (is_digit) begin
            mode_next   = (ch == CH_ZERO) ? M_ZERO : M_DEC;
            tstart_next = pos;
            run_next    = RUN_W'(1);
          end
        end
      endcase
    end

    if (ended) begin
      mode_next   = M_IDLE;
      pos_next    = '0;
      tstart_next = '0;
      run_next    = '0;
      prefix_next = '0;
    end else begin
      pos_next = (pos < POS_MAX) ? pos + 1'b1 : POS_MAX;
    end

    held_res.last = !new_emit;
  end

  // Pack results from slot 0; report nothing unless the byte advances
  always_comb begin
    push.r0 = held_emit ? held_res : new_res;
    push.r1 = new_res;
    if (!fire) begin
      push.n = 2'd0;
    end else begin
      push.n = {1'b0, held_emit} + {1'b0, new_emit};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode   <= M_IDLE;
      pos    <= '0;
      tstart <= '0;
      run    <= '0;
      prefix <= '0;
    end else if (fire) begin
      mode   <= mode_next;
      pos    <= pos_next;
      tstart <= tstart_next;
      run    <= run_next;
      prefix <= prefix_next;
    end
  end

endmodule

/* rtl/core/kwl_outq.sv */
module kwl_outq (
  input  logic                 clk,
  input  logic                 rst,
  input  kwl_pkg::kwl_push_t   push,
  output logic                 room,
  output logic                 out_valid,
  input  logic                 out_stall,
  output kwl_pkg::kwl_result_t head
);
  import kwl_pkg::*;

  kwl_result_t         entries [OQ_DEPTH];
  logic [OQ_PTR_W-1:0] wr, rd;
  logic [OQ_CNT_W-1:0] count;
  logic                pop;

  assign out_valid = (count != '0);
  assign pop       = out_valid && !out_stall;
  assign head      = entries[rd];
  // Two free slots cover the worst byte
  assign room      = (count <= OQ_CNT_W'(OQ_DEPTH - 2));

  always_ff @(posedge clk) begin
    if (push.n != 2'd0) begin
      entries[wr] <= push.r0;
    end
    if (push.n == 2'd2) begin
      entries[wr + 1'b1] <= push.r1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr    <= '0;
      rd    <= '0;
      count <= '0;
    end else begin
      wr    <= wr + OQ_PTR_W'(push.n);
      rd    <= rd + OQ_PTR_W'(pop);
      count <= count + OQ_CNT_W'(push.n) - OQ_CNT_W'(pop);
    end
  end

endmodule

/* rtl/core/keyword_lexer_core.sv */
// Streaming keyword lexer. Feed source text one byte per request on ch; a
// zero byte ends the text, flushes any open token, emits an end token and
// returns the block to its reset state so the next byte is offset 0 of a new
// text. Each result request carries token_kind, start_offset, token_length
// (0 on the end token) and last_of_run, which marks the final result caused
// by one input byte. Punctuation tokens come out at once; words, keywords,
// decimal and 0x address literals, and '-' versus "->" are held until a byte
// arrives that cannot extend them, so one byte can cause two results (the
// closed token, then its own). Bytes no rule accepts separate tokens and are
// dropped. Offsets saturate at TEXT_DEPTH-1 and every reported offset and
// length is capped at 16383. Timing: a byte is taken into the input register
// and scanned there against the lexer state, and its results are written into
// a four-entry output queue whose head drives the outputs, so a result passes
// through the input register and the queue before it is presented. The input
// takes a byte every cycle while the queue has two free slots; the output
// drains one result per cycle while out_stall is low, so sustained rate is one
// byte per cycle except when bytes cause more than one result on average for
// long stretches, where the output port sets the pace.
module keyword_lexer_core #(
  parameter int TEXT_DEPTH = kwl_pkg::TEXT_DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [kwl_pkg::CH_W-1:0]    ch,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [kwl_pkg::KIND_W-1:0]  token_kind,
  output logic [kwl_pkg::FIELD_W-1:0] start_offset,
  output logic [kwl_pkg::FIELD_W-1:0] token_length,
  output logic                        last_of_run
);
  import kwl_pkg::*;

  // Input register
  logic             hold_valid;
  logic [CH_W-1:0]  hold_ch;
  logic             fire;
  logic             room;
  kwl_push_t        push;
  kwl_result_t      head;

  // Advance the held byte only when the queue can take both of its results
  assign fire     = hold_valid && room;
  assign in_stall = hold_valid && !room;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (!in_stall) begin
      hold_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      hold_ch <= ch;
    end
  end

  kwl_scan #(
    .TEXT_DEPTH(TEXT_DEPTH)
  ) u_scan (
    .clk  (clk),
    .rst  (rst),
    .fire (fire),
    .ch   (hold_ch),
    .push (push)
  );

  kwl_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .room      (room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .head      (head)
  );

  assign token_kind   = head.kind;
  assign start_offset = head.start;
  assign token_length = head.len;
  assign last_of_run  = head.last;

endmodule

/* test/testbench.sv */
`timescale 1ns / 100ps

module testbench;
  import kwl_pkg::*;

  // Scanner modes of the token predictor; the block keeps its own encoding.
  typedef enum logic [2:0] {
    SCAN_IDLE,
    SCAN_DASH,
    SCAN_WORD,
    SCAN_ZERO,
    SCAN_DEC,
    SCAN_HEX
  } scan_mode_t;

  localparam logic [FIELD_W-1:0] POS_LIMIT = FIELD_W'(TEXT_DEPTH_DEF - 1);

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [CH_W-1:0]     ch = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [KIND_W-1:0]   token_kind;
  logic [FIELD_W-1:0]  start_offset;
  logic [FIELD_W-1:0]  token_length;
  logic                last_of_run;

  // Predictor state, mirrors what the lexer holds between bytes
  scan_mode_t          lex_mode = SCAN_IDLE;
  logic [FIELD_W-1:0]  lex_pos = '0;
  logic [FIELD_W-1:0]  lex_start = '0;
  logic [FIELD_W-1:0]  lex_run = '0;
  logic [PREFIX_W-1:0] lex_prefix = '0;

  // Tokens predicted but not yet seen on the output, oldest first
  kwl_result_t         pending_tokens[$];
  kwl_result_t         want_tok;

  int                  error_count = 0;
  int                  tokens_seen = 0;
  int                  bytes_sent = 0;
  int                  send_idle_pct = 0;
  int                  recv_idle_pct = 0;

  string kw_words [14] = '{"int", "addr", "addrArr", "arr", "mem", "str", "main",
                           "static", "NULL", "null", "Null", "for", "if", "print"};

  keyword_lexer_core u_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .ch           (ch),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .token_kind   (token_kind),
    .start_offset (start_offset),
    .token_length (token_length),
    .last_of_run  (last_of_run)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // ---------------------------------------------------------------------------
  // Token predictor
  // ---------------------------------------------------------------------------

  function automatic logic is_letter(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic [FIELD_W-1:0] bump(logic [FIELD_W-1:0] v);
    return (v == FIELD_MAX) ? v : v + 1'b1;
  endfunction

  // Keywords match only on the whole word; anything past seven bytes is a name.
  function automatic token_kind_t word_kind_of(logic [FIELD_W-1:0] run,
                                               logic [PREFIX_W-1:0] prefix);
    token_kind_t k;
    k = TK_IDENT;
    if (run <= FIELD_W'(KW_MAX_LEN)) begin
      case (prefix)
        "int":     k = TK_INT;
        "addr":    k = TK_ADDR;
        "addrArr": k = TK_ADDRARR;
        "arr":     k = TK_ARR;
        "mem":     k = TK_MEM;
        "str":     k = TK_STR;
        "main":    k = TK_MAIN;
        "static":  k = TK_STATIC;
        "NULL":    k = TK_NULL;
        "null":    k = TK_NULL;
        "Null":    k = TK_NULL;
        "for":     k = TK_FOR;
        "if":      k = TK_IF;
        "print":   k = TK_PRINT;
        default:   k = TK_IDENT;
      endcase
    end
    return k;
  endfunction

  function automatic void push_token(token_kind_t k, logic [FIELD_W-1:0] s,
                                     logic [FIELD_W-1:0] l);
    kwl_result_t t;
    t.kind  = k;
    t.start = s;
    t.len   = l;
    t.last  = 1'b0;
    pending_tokens.push_back(t);
  endfunction

  function automatic void open_token(scan_mode_t m, logic [FIELD_W-1:0] p);
    lex_mode  = m;
    lex_start = p;
    lex_run   = FIELD_W'(1);
  endfunction

  // Advance the predictor by one accepted byte and queue the tokens it closes.
  function automatic void predict_tokens(logic [7:0] c);
    logic [FIELD_W-1:0] p;
    logic               held;
    logic               text_end;
    int                 q_size0;
    p        = lex_pos;
    held     = 1'b0;
    text_end = 1'b0;
    q_size0  = pending_tokens.size();

    // First let the open token either swallow the byte or close.
    case (lex_mode)
      SCAN_DASH: begin
        if (c == CH_GT) begin
          push_token(TK_ARROW, lex_start, FIELD_W'(2));
          lex_mode = SCAN_IDLE;
          held = 1'b1;
        end else begin
          push_token(TK_SUB, lex_start, FIELD_W'(1));
        end
      end
      SCAN_WORD: begin
        if (is_letter(c) || is_digit(c)) begin
          if (lex_run < FIELD_W'(KW_MAX_LEN)) begin
            lex_prefix = {lex_prefix[PREFIX_W-9:0], c};
          end
          lex_run = bump(lex_run);
          held = 1'b1;
        end else begin
          push_token(word_kind_of(lex_run, lex_prefix), lex_start, lex_run);
        end
      end
      SCAN_ZERO: begin
        if (c == CH_X) begin
          lex_mode = SCAN_HEX;
          lex_run = FIELD_W'(2);
          held = 1'b1;
        end else if (is_digit(c)) begin
          lex_mode = SCAN_DEC;
          lex_run = bump(lex_run);
          held = 1'b1;
        end else begin
          push_token(TK_INTDATA, lex_start, lex_run);
        end
      end
      SCAN_DEC: begin
        if (is_digit(c)) begin
          lex_run = bump(lex_run);
          held = 1'b1;
        end else begin
          push_token(TK_INTDATA, lex_start, lex_run);
        end
      end
      SCAN_HEX: begin
        if (is_letter(c) || is_digit(c)) begin
          lex_run = bump(lex_run);
          held = 1'b1;
        end else begin
          push_token(TK_ADDRDATA, lex_start, lex_run);
        end
      end
      default: ;
    endcase

    // A byte not swallowed above is scanned as the start of something new.
    if (!held) begin
      lex_mode = SCAN_IDLE;
      case (c)
        CH_NUL: begin
          push_token(TK_END, p, '0);
          text_end = 1'b1;
        end
        CH_LPAREN: push_token(TK_LPAREN, p, FIELD_W'(1));
        CH_RPAREN: push_token(TK_RPAREN, p, FIELD_W'(1));
        CH_LBRACE: push_token(TK_LBRACE, p, FIELD_W'(1));
        CH_RBRACE: push_token(TK_RBRACE, p, FIELD_W'(1));
        CH_EQUAL:  push_token(TK_EQUAL, p, FIELD_W'(1));
        CH_COMMA:  push_token(TK_COMMA, p, FIELD_W'(1));
        CH_PLUS:   push_token(TK_SUM, p, FIELD_W'(1));
        CH_STAR:   push_token(TK_MULT, p, FIELD_W'(1));
        CH_SLASH:  push_token(TK_DIV, p, FIELD_W'(1));
        CH_AT:     push_token(TK_AT, p, FIELD_W'(1));
        CH_DASH:   open_token(SCAN_DASH, p);
        default: begin
          if (is_letter(c)) begin
            open_token(SCAN_WORD, p);
            lex_prefix = PREFIX_W'(c);
          end else if (is_digit(c)) begin
            open_token((c == CH_ZERO) ? SCAN_ZERO : SCAN_DEC, p);
          end
        end
      endcase
    end

    // End of text puts everything back to its reset values.
    if (text_end) begin
      lex_mode   = SCAN_IDLE;
      lex_pos    = '0;
      lex_start  = '0;
      lex_run    = '0;
      lex_prefix = '0;
    end else begin
      lex_pos = (p >= POS_LIMIT) ? POS_LIMIT : p + 1'b1;
    end

    if (pending_tokens.size() > q_size0) begin
      pending_tokens[pending_tokens.size()-1].last = 1'b1;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Request driver
  // ---------------------------------------------------------------------------

  // Drive one byte, hold it until taken, then predict its tokens.
  task automatic send_byte(input logic [7:0] c);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    ch       <= c;
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
    predict_tokens(c);
    bytes_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      send_byte(s[i]);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result checker
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string what);
    error_count++;
    $display("ERROR at %0t: %s", $time, what);
  endtask

  // Compare each taken result with the oldest prediction; draw a fresh stall.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_tokens.size() == 0) begin
        report_mismatch($sformatf("token %0d: kind %0d start %0d len %0d with none pending",
                                  tokens_seen, token_kind, start_offset, token_length));
      end else begin
        want_tok = pending_tokens.pop_front();
        if (token_kind !== want_tok.kind || start_offset !== want_tok.start ||
            token_length !== want_tok.len || last_of_run !== want_tok.last) begin
          report_mismatch($sformatf(
            "token %0d: got kind %0d start %0d len %0d last %b, want %0d %0d %0d %b",
            tokens_seen, token_kind, start_offset, token_length, last_of_run,
            want_tok.kind, want_tok.start, want_tok.len, want_tok.last));
        end
      end
      tokens_seen++;
    end
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // ---------------------------------------------------------------------------
  // Random source text
  // ---------------------------------------------------------------------------

  function automatic logic [7:0] rand_word_start();
    int r;
    r = $urandom_range(52);
    if (r < 26) return 8'("a" + r);
    if (r < 52) return 8'("A" + r - 26);
    return "_";
  endfunction

  function automatic logic [7:0] rand_word_char();
    if ($urandom_range(4) == 0) return 8'(CH_ZERO + $urandom_range(9));
    return rand_word_start();
  endfunction

  function automatic logic [7:0] rand_punct();
    case ($urandom_range(10))
      0:       return CH_LPAREN;
      1:       return CH_RPAREN;
      2:       return CH_LBRACE;
      3:       return CH_RBRACE;
      4:       return CH_EQUAL;
      5:       return CH_COMMA;
      6:       return CH_PLUS;
      7:       return CH_STAR;
      8:       return CH_SLASH;
      9:       return CH_AT;
      default: return CH_DASH;
    endcase
  endfunction

  // Bytes that no rule takes; '>' only counts right after a dash.
  function automatic logic [7:0] rand_separator();
    case ($urandom_range(4))
      0:       return "\n";
      1:       return "\t";
      2:       return ";";
      3:       return CH_GT;
      default: return " ";
    endcase
  endfunction

  // One text of mostly well-formed tokens, sometimes run together, with some
  // noise bytes; most texts close with a zero byte, a few run on.
  task automatic send_random_text();
    int    n_tok;
    string kw;
    n_tok = $urandom_range(1, 12);
    repeat (n_tok) begin
      case ($urandom_range(15))
        0, 1, 2, 3: send_text(kw_words[$urandom_range(13)]);
        4: begin
          // near miss: keyword cut short or stretched by one byte
          kw = kw_words[$urandom_range(13)];
          if ($urandom_range(1)) begin
            send_text(kw.substr(0, kw.len() - 2));
          end else begin
            send_text(kw);
            send_byte(rand_word_char());
          end
        end
        5, 6: begin
          send_byte(rand_word_start());
          repeat ($urandom_range(0, 9)) send_byte(rand_word_char());
        end
        7: repeat ($urandom_range(1, 5)) send_byte(8'(CH_ZERO + $urandom_range(9)));
        8: begin
          send_byte(CH_ZERO);
          send_byte(CH_X);
          repeat ($urandom_range(0, 5)) send_byte(rand_word_char());
        end
        9: send_byte(CH_ZERO);
        10, 11: send_byte(rand_punct());
        12: begin
          send_byte(CH_DASH);
          send_byte(CH_GT);
        end
        13: send_byte(rand_separator());
        default: send_byte(8'($urandom_range(1, 255)));
      endcase
      if ($urandom_range(9) < 6) begin
        send_byte(rand_separator());
      end
    end
    if ($urandom_range(9) != 0) begin
      send_byte(CH_NUL);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Every single-byte punctuation token but the dash, dropped bytes with the top
  // bit set, and an end token with nothing open.
  task automatic test_punctuation();
    send_text("(){}=,+*/@>;");
    send_byte(8'hFF);
    send_byte(8'h80);
    send_byte(CH_NUL);
  endtask

  // Arrow, lone dash, bare 0x, address literal, zero-led decimal, capital X
  // after zero, and a dash flushed by the end of text.
  task automatic test_literals();
    send_text("->-x-0x 0xA_9 007 0X1-");
    send_byte(CH_NUL);
  endtask

  // Longest keyword, the same word one byte longer, case-sensitive Null, and
  // a word closed by punctuation.
  task automatic test_words();
    send_text("int addrArr addrArrx Null(");
    send_byte(CH_NUL);
  endtask

  task automatic test_random_texts(input int n_bytes);
    int first;
    first = bytes_sent;
    while (bytes_sent - first < n_bytes) begin
      send_random_text();
    end
    send_byte(CH_NUL);
  endtask

  // Word that starts like a keyword and runs far past the keyword width,
  // then tokens that follow it in the same text.
  task automatic test_long_text();
    send_text("static");
    repeat (34) send_byte("b");
    send_text("(-12");
    send_byte(CH_NUL);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Receiver-bound phase
    send_idle_pct = 21;
    recv_idle_pct = 71;
    test_punctuation();
    test_literals();
    test_words();
    test_random_texts(110);

    // Sender-bound phase
    send_idle_pct = 71;
    recv_idle_pct = 21;
    test_random_texts(110);

    // Full rate
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_texts(110);
    test_long_text();
    in_valid <= 1'b0;

    // Drain, then give the output queue time to show any stray result.
    while (pending_tokens.size() != 0) begin
      @(posedge clk);
    end
    repeat (20) @(posedge clk);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #5ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

/* keyword_lexer_core.f */
rtl/core/kwl_pkg.sv
rtl/core/kwl_scan.sv
rtl/core/kwl_outq.sv
rtl/core/keyword_lexer_core.sv
test/testbench.sv
